// ===== rtl/digest_header_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DIGEST_HEADER_TOKENIZER_DEFINES_SVH
`define DIGEST_HEADER_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define DHT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dht: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define DHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dht: next-cycle check failed");

`endif

// ===== rtl/dht_pkg.sv =====
package dht_pkg;

  localparam int NAME_COUNT     = 10;
  localparam int KEY_NAME_BYTES = 8;

  localparam logic [2:0] PH_BEFORE_KEY = 3'd0;
  localparam logic [2:0] PH_IN_KEY     = 3'd1;
  localparam logic [2:0] PH_BEFORE_EQ  = 3'd2;
  localparam logic [2:0] PH_BEFORE_VAL = 3'd3;
  localparam logic [2:0] PH_OPEN_QUOTE = 3'd4;
  localparam logic [2:0] PH_IN_VAL     = 3'd5;
  localparam logic [2:0] PH_AFTER_VAL  = 3'd6;

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_KEY   = 2'd1;
  localparam logic [1:0] CLASS_VALUE = 2'd2;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [3:0] PREFIX_SKIP_RESET = 4'd6;
  localparam logic [3:0] KEY_ID_UNKNOWN    = 4'd0;

  typedef logic [NAME_COUNT-1:0] cand_t;
  typedef logic [0:KEY_NAME_BYTES-1][7:0] key_text_t;

  localparam cand_t ALL_CANDIDATES = '1;

  // Names are stored left aligned: byte 0 holds the first character.
  localparam key_text_t KEY_TEXT [NAME_COUNT] = '{
    {"nonce", 24'h0},
    {"uri", 40'h0},
    {"method", 16'h0},
    {"username"},
    {"cnonce", 16'h0},
    {"nc", 48'h0},
    {"opaque", 16'h0},
    {"qop", 40'h0},
    {"response"},
    {"realm", 24'h0}
  };

  localparam logic [3:0] KEY_LEN [NAME_COUNT] = '{
    4'd5, 4'd3, 4'd6, 4'd8, 4'd6, 4'd2, 4'd6, 4'd3, 4'd8, 4'd5
  };

  typedef struct packed {
    logic [7:0] echo_byte;
    logic [1:0] byte_class;
    logic       pair_end;
    logic [3:0] key_id;
    logic       header_last;
  } result_t;

endpackage

// ===== rtl/dht_in_if.sv =====
interface dht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       header_end;

  modport source (output valid, output data_byte, output header_end, input ready);
  modport sink (input valid, input data_byte, input header_end, output ready);
endinterface

// ===== rtl/dht_out_if.sv =====
interface dht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [1:0] byte_class;
  logic       pair_end;
  logic [3:0] key_id;
  logic       header_last;

  modport source (
    output valid, output echo_byte, output byte_class, output pair_end,
    output key_id, output header_last, input ready
  );
  modport sink (
    input valid, input echo_byte, input byte_class, input pair_end,
    input key_id, input header_last, output ready
  );
endinterface

// ===== rtl/dht_key_unit.sv =====
module dht_key_unit (
  input  dht_pkg::cand_t cand_in,
  input  logic [3:0]     len_in,
  input  logic [7:0]     key_byte,
  output dht_pkg::cand_t cand_out,
  output logic [3:0]     len_out,
  output logic [3:0]     match_id
);
  import dht_pkg::*;

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      cand_out[i] = cand_in[i] && (len_in < KEY_LEN[i]) &&
                    (KEY_TEXT[i][len_in[2:0]] == key_byte);
    end
  end

  assign len_out = (len_in == 4'hF) ? len_in : len_in + 4'd1;

  // The lowest matching index wins.
  always_comb begin
    match_id = KEY_ID_UNKNOWN;
    for (int i = NAME_COUNT - 1; i >= 0; i--) begin
      if (cand_in[i] && (len_in == KEY_LEN[i])) begin
        match_id = 4'(i + 1);
      end
    end
  end
endmodule

// ===== rtl/dht_parser.sv =====
`include "digest_header_tokenizer_defines.svh"

module dht_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [3:0]       cfg_wr_data,
  input  logic             step_en,
  input  logic [7:0]       data_byte,
  input  logic             header_end,
  output dht_pkg::result_t res
);
  import dht_pkg::*;

  logic [3:0] prefix_skip_r;
  logic [2:0] phase_r, phase_nxt;
  logic       quoted_r, quoted_nxt;
  logic [3:0] skip_count_r, skip_count_nxt;
  cand_t      cand_r, cand_nxt;
  logic [3:0] key_len_r, key_len_nxt;
  logic [3:0] held_key_r, held_key_nxt;

  cand_t      feed_cand_in, feed_cand_out;
  logic [3:0] feed_len_in, feed_len_out, match_id;
  logic [1:0] cls;
  logic       done;

  assign feed_cand_in = (phase_r == PH_IN_KEY) ? cand_r : ALL_CANDIDATES;
  assign feed_len_in  = (phase_r == PH_IN_KEY) ? key_len_r : 4'd0;

  dht_key_unit u_key (
    .cand_in  (feed_cand_in),
    .len_in   (feed_len_in),
    .key_byte (data_byte),
    .cand_out (feed_cand_out),
    .len_out  (feed_len_out),
    .match_id (match_id)
  );

  always_comb begin
    phase_nxt      = phase_r;
    quoted_nxt     = quoted_r;
    skip_count_nxt = skip_count_r;
    cand_nxt       = cand_r;
    key_len_nxt    = key_len_r;
    held_key_nxt   = held_key_r;
    cls            = CLASS_NONE;
    done           = 1'b0;

    if (skip_count_r < prefix_skip_r) begin
      skip_count_nxt = skip_count_r + 4'd1;
    end else begin
      unique case (phase_r)
        PH_IN_KEY: begin
          if (data_byte == CH_EQ || data_byte == CH_SPACE) begin
            held_key_nxt = match_id;
            phase_nxt    = (data_byte == CH_EQ) ? PH_BEFORE_VAL : PH_BEFORE_EQ;
          end else begin
            cls         = CLASS_KEY;
            cand_nxt    = feed_cand_out;
            key_len_nxt = feed_len_out;
          end
        end
        PH_BEFORE_EQ: begin
          if (data_byte == CH_EQ) begin
            phase_nxt = PH_BEFORE_VAL;
          end
        end
        PH_BEFORE_VAL: begin
          if (data_byte == CH_QUOTE) begin
            quoted_nxt = 1'b1;
            phase_nxt  = PH_OPEN_QUOTE;
          end else if (data_byte != CH_SPACE) begin
            quoted_nxt = 1'b0;
            phase_nxt  = PH_IN_VAL;
            cls        = CLASS_VALUE;
            done       = header_end;
          end
        end
        PH_OPEN_QUOTE: begin
          if (data_byte == CH_QUOTE) begin
            done      = 1'b1;
            phase_nxt = PH_AFTER_VAL;
          end else begin
            cls       = CLASS_VALUE;
            phase_nxt = PH_IN_VAL;
          end
        end
        PH_IN_VAL: begin
          if (quoted_r) begin
            if (data_byte == CH_QUOTE) begin
              done      = 1'b1;
              phase_nxt = PH_AFTER_VAL;
            end else begin
              cls = CLASS_VALUE;
            end
          end else if (data_byte == CH_SPACE) begin
            done      = 1'b1;
            phase_nxt = PH_AFTER_VAL;
          end else if (data_byte == CH_COMMA) begin
            done      = 1'b1;
            phase_nxt = PH_BEFORE_KEY;
          end else begin
            cls  = CLASS_VALUE;
            done = header_end;
          end
        end
        PH_AFTER_VAL: begin
          if (data_byte == CH_COMMA) begin
            phase_nxt = PH_BEFORE_KEY;
          end
        end
        default: begin
          if (data_byte != CH_SPACE) begin
            cls         = CLASS_KEY;
            cand_nxt    = feed_cand_out;
            key_len_nxt = feed_len_out;
            phase_nxt   = PH_IN_KEY;
          end
        end
      endcase
    end

    if (header_end) begin
      phase_nxt      = PH_BEFORE_KEY;
      quoted_nxt     = 1'b0;
      skip_count_nxt = 4'd0;
      cand_nxt       = ALL_CANDIDATES;
      key_len_nxt    = 4'd0;
      held_key_nxt   = KEY_ID_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_skip_r <= PREFIX_SKIP_RESET;
      phase_r       <= PH_BEFORE_KEY;
      quoted_r      <= 1'b0;
      skip_count_r  <= 4'd0;
      cand_r        <= ALL_CANDIDATES;
      key_len_r     <= 4'd0;
      held_key_r    <= KEY_ID_UNKNOWN;
    end else begin
      if (cfg_wr_en) begin
        prefix_skip_r <= cfg_wr_data;
      end
      if (step_en) begin
        phase_r      <= phase_nxt;
        quoted_r     <= quoted_nxt;
        skip_count_r <= skip_count_nxt;
        cand_r       <= cand_nxt;
        key_len_r    <= key_len_nxt;
        held_key_r   <= held_key_nxt;
      end
    end
  end

  assign res.echo_byte   = data_byte;
  assign res.byte_class  = cls;
  assign res.pair_end    = done;
  assign res.key_id      = done ? held_key_r : KEY_ID_UNKNOWN;
  assign res.header_last = header_end;

  `DHT_ASSERT_SAME(a_pair_end_not_key, step_en && done, cls != CLASS_KEY)
  `DHT_ASSERT_SAME(a_key_id_only_on_end, res.key_id != KEY_ID_UNKNOWN, done)
  `DHT_ASSERT_SAME(a_in_key_has_length, phase_r == PH_IN_KEY, key_len_r != 4'd0)
  `DHT_ASSERT_NEXT(a_header_end_clears, step_en && header_end,
                   phase_r == PH_BEFORE_KEY && skip_count_r == 4'd0 &&
                   cand_r == ALL_CANDIDATES && key_len_r == 4'd0)
endmodule

// ===== rtl/digest_header_tokenizer.sv =====
// Channel   Direction  Beat contents
// in_if     sink       data_byte, header_end
// out_if    source     echo_byte, byte_class, pair_end, key_id, header_last
// cfg_*     write      prefix_skip (4 bits), no read-back
//
// Each header byte passes an input register and a result register; one beat is accepted per cycle
// unless the result register stalls. The parse state updates as a beat moves to the result register.
// Reset is synchronous; it empties both registers and sets prefix_skip to 6.
// A stalled result register holds its beat while an empty input register still takes one more beat.
module digest_header_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  dht_in_if.sink     in_if,
  dht_out_if.source  out_if,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  import dht_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    step_res;
  logic       out_free;
  logic       step_en;

  assign out_free    = !out_valid_r || out_if.ready;
  assign step_en     = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;

  dht_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .data_byte   (in_byte_r),
    .header_end  (in_end_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
      in_end_r  <= in_if.header_end;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.echo_byte   = out_res_r.echo_byte;
  assign out_if.byte_class  = out_res_r.byte_class;
  assign out_if.pair_end    = out_res_r.pair_end;
  assign out_if.key_id      = out_res_r.key_id;
  assign out_if.header_last = out_res_r.header_last;
endmodule

// ===== tb/sv/digest_header_tokenizer_test.sv =====
module digest_header_tokenizer_test;
  import dht_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1550;
  localparam int PHASES = 8;

  class token_scoreboard;
    string key_names[NAME_COUNT] = '{"nonce", "uri", "method", "username", "cnonce",
                                     "nc", "opaque", "qop", "response", "realm"};
    logic [3:0] skip_len = PREFIX_SKIP_RESET;
    logic [2:0] tok_state;
    logic       in_quotes;
    logic [3:0] skipped;
    cand_t      live_names;
    logic [3:0] key_bytes;
    logic [3:0] pending_key;
    result_t    expected_tokens[$];
    int         errors = 0;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      tok_state = PH_BEFORE_KEY;
      in_quotes = 1'b0;
      skipped = 4'd0;
      live_names = ALL_CANDIDATES;
      key_bytes = 4'd0;
      pending_key = KEY_ID_UNKNOWN;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void feed_key(logic [7:0] c);
      for (int i = 0; i < NAME_COUNT; i++) begin
        if (live_names[i] && !(key_bytes < key_names[i].len() && key_names[i][key_bytes] == c)) begin
          live_names[i] = 1'b0;
        end
      end
      if (key_bytes != 4'd15) begin
        key_bytes++;
      end
    endfunction

    function logic [3:0] match_key();
      for (int i = 0; i < NAME_COUNT; i++) begin
        if (live_names[i] && key_bytes == key_names[i].len()) begin
          return 4'(i + 1);
        end
      end
      return KEY_ID_UNKNOWN;
    endfunction

    function void absorb_byte(logic [7:0] c, logic last);
      result_t r;
      r.echo_byte = c;
      r.byte_class = CLASS_NONE;
      r.pair_end = 1'b0;
      r.key_id = KEY_ID_UNKNOWN;
      r.header_last = last;
      if (skipped < skip_len) begin
        skipped++;
      end else begin
        case (tok_state)
          PH_IN_KEY: begin
            if (c == CH_EQ || c == CH_SPACE) begin
              pending_key = match_key();
              tok_state = (c == CH_EQ) ? PH_BEFORE_VAL : PH_BEFORE_EQ;
            end else begin
              r.byte_class = CLASS_KEY;
              feed_key(c);
            end
          end
          PH_BEFORE_EQ: begin
            if (c == CH_EQ) tok_state = PH_BEFORE_VAL;
          end
          PH_BEFORE_VAL: begin
            if (c == CH_QUOTE) begin
              in_quotes = 1'b1;
              tok_state = PH_OPEN_QUOTE;
            end else if (c != CH_SPACE) begin
              in_quotes = 1'b0;
              tok_state = PH_IN_VAL;
              r.byte_class = CLASS_VALUE;
              r.pair_end = last;
            end
          end
          PH_OPEN_QUOTE: begin
            if (c == CH_QUOTE) begin
              r.pair_end = 1'b1;
              tok_state = PH_AFTER_VAL;
            end else begin
              r.byte_class = CLASS_VALUE;
              tok_state = PH_IN_VAL;
            end
          end
          PH_IN_VAL: begin
            if (in_quotes) begin
              if (c == CH_QUOTE) begin
                r.pair_end = 1'b1;
                tok_state = PH_AFTER_VAL;
              end else begin
                r.byte_class = CLASS_VALUE;
              end
            end else if (c == CH_SPACE) begin
              r.pair_end = 1'b1;
              tok_state = PH_AFTER_VAL;
            end else if (c == CH_COMMA) begin
              r.pair_end = 1'b1;
              tok_state = PH_BEFORE_KEY;
            end else begin
              r.byte_class = CLASS_VALUE;
              r.pair_end = last;
            end
          end
          PH_AFTER_VAL: begin
            if (c == CH_COMMA) tok_state = PH_BEFORE_KEY;
          end
          default: begin
            if (c != CH_SPACE) begin
              r.byte_class = CLASS_KEY;
              live_names = ALL_CANDIDATES;
              key_bytes = 4'd0;
              feed_key(c);
              tok_state = PH_IN_KEY;
            end
          end
        endcase
      end
      if (r.pair_end) r.key_id = pending_key;
      expected_tokens.push_back(r);
      if (last) clear_parse();
    endfunction

    function void check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result beat, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.echo_byte !== want.echo_byte) begin
        $display("%0t: echo_byte expected %h got %h", $time, want.echo_byte, got.echo_byte);
        errors++;
      end
      if (got.byte_class !== want.byte_class) begin
        $display("%0t: byte_class expected %0d got %0d", $time, want.byte_class,
                 got.byte_class);
        errors++;
      end
      if (got.pair_end !== want.pair_end) begin
        $display("%0t: pair_end expected %b got %b", $time, want.pair_end, got.pair_end);
        errors++;
      end
      if (got.key_id !== want.key_id) begin
        $display("%0t: key_id expected %0d got %0d", $time, want.key_id, got.key_id);
        errors++;
      end
      if (got.header_last !== want.header_last) begin
        $display("%0t: header_last expected %b got %b", $time, want.header_last,
                 got.header_last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  dht_in_if  in_ch ();
  dht_out_if out_ch ();

  digest_header_tokenizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  token_scoreboard sb = new();
  result_t seen;
  int cycle_count = 0;
  int beats_sent = 0;
  int burst_left = 0;
  int gap_len;
  int stall_mode;
  int stall_span;
  int stall_tick = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(32, 160);
      repeat (stall_span) begin
        @(posedge clk);
        stall_tick++;
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (stall_tick % 7) < 4;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("digest_header_tokenizer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.echo_byte = out_ch.echo_byte;
        seen.byte_class = out_ch.byte_class;
        seen.pair_end = out_ch.pair_end;
        seen.key_id = out_ch.key_id;
        seen.header_last = out_ch.header_last;
        sb.check_token(seen);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.absorb_byte(in_ch.data_byte, in_ch.header_end);
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.header_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) begin
      send_beat(s[k], k == s.len() - 1);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_prefix_skip(logic [3:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.skip_len = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] quoted_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(32, 126)); while (ch == CH_QUOTE);
    return ch;
  endfunction

  function automatic logic [7:0] bare_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(33, 126)); while (ch == CH_QUOTE || ch == CH_COMMA);
    return ch;
  endfunction

  task automatic send_header();
    logic [7:0] hdr[$];
    string name;
    int pairs;
    int keep;
    repeat (sb.skip_len) hdr.push_back(8'($urandom_range(0, 255)));
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      if ($urandom_range(0, 4) == 0) hdr.push_back(CH_SPACE);
      if ($urandom_range(0, 3) != 0) begin
        name = sb.key_names[$urandom_range(0, NAME_COUNT - 1)];
        for (int k = 0; k < name.len(); k++) hdr.push_back(name[k]);
      end else begin
        repeat ($urandom_range(1, 18)) hdr.push_back(8'($urandom_range(97, 122)));
      end
      if ($urandom_range(0, 4) == 0) hdr.push_back(CH_SPACE);
      hdr.push_back(CH_EQ);
      if ($urandom_range(0, 4) == 0) hdr.push_back(CH_SPACE);
      if ($urandom_range(0, 1) == 0) begin
        hdr.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) hdr.push_back(quoted_char());
        hdr.push_back(CH_QUOTE);
      end else begin
        repeat ($urandom_range(1, 6)) hdr.push_back(bare_char());
      end
      if (p < pairs - 1) begin
        if ($urandom_range(0, 1) == 0) hdr.push_back(CH_SPACE);
        hdr.push_back(CH_COMMA);
        if ($urandom_range(0, 1) == 0) hdr.push_back(CH_SPACE);
      end
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        keep = $urandom_range(1, hdr.size());
        while (hdr.size() > keep) void'(hdr.pop_back());
      end
      2: hdr.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COMMA);
      default: ;
    endcase
    for (int k = 0; k < hdr.size(); k++) begin
      send_beat(hdr[k], k == hdr.size() - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      send_beat(8'($urandom_range(0, 255)),
                ($urandom_range(0, 7) == 0) || (k == n - 1 && $urandom_range(0, 1) == 1));
    end
  endtask

  initial begin
    logic [3:0] settings[PHASES];
    int target;
    settings = '{4'd15, 4'd0, 4'd6, 4'd1, 4'd9, 4'd15, 4'd0, 4'd3};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.header_end = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_prefix_skip(4'd0);
    send_text("qop=\"\"");
    send_text("uri=z");
    send_text("= =,");
    send_beat(8'hFF, 1'b0);
    send_beat(CH_EQ, 1'b0);
    send_beat(8'h00, 1'b1);
    send_text("nc=1 ");
    send_text("realm");
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_prefix_skip(ph < 5 ? settings[ph] : 4'($urandom_range(0, 15)));
      target = beats_sent + RANDOM_BEATS / PHASES;
      while (beats_sent < target) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_header();
      end
      // A partial header left open here lets the next write land mid-prefix.
      repeat ($urandom_range(0, 5)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("digest_header_tokenizer verification clean");
    end else begin
      $display("digest_header_tokenizer verification failed");
    end
    $finish;
  end
endmodule
